// ===== rtl/qrr_pkg.sv =====
// ----------------------------------------------------------------------------
// qrr_pkg: shared definitions for the quota round-robin list merge
// Field widths, register reset values, operation and register codes,
// controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qrr_pkg;

  // Default sizes for the top-level parameters.
  localparam int NUM_LISTS_DEF  = 6;
  localparam int LIST_DEPTH_DEF = 64;
  localparam int TAG_WIDTH_DEF  = 16;

  // Fixed field widths.
  localparam int OP_W       = 2;
  localparam int LIST_IDX_W = 3;
  localparam int QUOTA_W    = 4;
  localparam int CAP_W      = 8;
  localparam int QUOTAS_W   = 24;
  localparam int CAPS_W     = 48;
  localparam int LIMIT_W    = 10;
  localparam int LIU_W      = 3;
  localparam int ACT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Register reset values.
  localparam logic [QUOTAS_W-1:0] QUOTAS_RST = 24'h111111;
  localparam logic [CAPS_W-1:0]   CAPS_RST   = 48'h030302020208;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 10'd20;
  localparam logic [LIU_W-1:0]    LISTS_RST  = 3'd6;

  // Pull status codes.
  localparam logic STATUS_ENTRY = 1'b0;
  localparam logic STATUS_DONE  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PULL  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUOTAS = 2'd0,
    CFG_CAPS   = 2'd1,
    CFG_LIMIT  = 2'd2,
    CFG_LISTS  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DELIVER,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic pull_start;
    logic scan;
    logic out_entry;
    logic out_finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic merge_done;
    logic hit;
    logic visit_done;
    logic out_busy;
  } dp_status_t;

  // Quota of a list; lists without a field and a zero field both give 1.
  function automatic logic [QUOTA_W-1:0] quota_of(input logic [QUOTAS_W-1:0] quotas,
                                                  input logic [LIST_IDX_W-1:0] idx);
    logic [31:0]        wide;
    logic [QUOTA_W-1:0] q;
    wide = {8'h00, quotas};
    q    = wide[{idx, 2'b00} +: QUOTA_W];
    return (q == '0) ? QUOTA_W'(1) : q;
  endfunction

  // Cap of a list; lists without a field have a cap of zero.
  function automatic logic [CAP_W-1:0] cap_of(input logic [CAPS_W-1:0] caps,
                                              input logic [LIST_IDX_W-1:0] idx);
    logic [63:0] wide;
    wide = {16'h0000, caps};
    return wide[{idx, 3'b000} +: CAP_W];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qrr_ifs.sv =====
// ----------------------------------------------------------------------------
// qrr_ifs: channel interfaces of the quota round-robin list merge
// Request, response and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface qrr_req_if #(
  parameter int TAG_W = qrr_pkg::TAG_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic [qrr_pkg::OP_W-1:0]          operation;
  logic [qrr_pkg::LIST_IDX_W-1:0]    list_index;
  logic [TAG_W-1:0]                  item_tag;

  modport source (output valid, operation, list_index, item_tag, input ready);
  modport sink   (input valid, operation, list_index, item_tag, output ready);
endinterface

interface qrr_rsp_if #(
  parameter int TAG_W = qrr_pkg::TAG_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic [TAG_W-1:0]                  merged_tag;
  logic [qrr_pkg::LIST_IDX_W-1:0]    source_list;
  logic                              pull_status;

  modport source (output valid, merged_tag, source_list, pull_status, input ready);
  modport sink   (input valid, merged_tag, source_list, pull_status, output ready);
endinterface

interface qrr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [qrr_pkg::CFG_IDX_W-1:0]     index;
  logic [qrr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/qrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// qrr_ctrl: merge controller
// Accepts request items, sequences the visit scan of a pull one visit per
// cycle, bounds the scan and hands results to the datapath's output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrr_ctrl #(
  parameter int NUM_LISTS = qrr_pkg::NUM_LISTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [qrr_pkg::OP_W-1:0] in_op,
  output logic                          in_ready,
  input  wire qrr_pkg::dp_status_t      status,
  output qrr_pkg::dp_cmd_t              cmd
);

  localparam int SCAN_BOUND = 3 * NUM_LISTS + 3;
  localparam int SCAN_W     = $clog2(SCAN_BOUND);

  qrr_pkg::state_t    state;
  qrr_pkg::state_t    state_next;
  logic [SCAN_W-1:0]  scan_cnt;
  logic               accept;
  logic               scan_last;

  assign in_ready  = (state == qrr_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign scan_last = (scan_cnt == SCAN_W'(SCAN_BOUND - 1));

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      qrr_pkg::S_IDLE: begin
        if (accept && (in_op == qrr_pkg::OP_PULL)) begin
          state_next = status.merge_done ? qrr_pkg::S_FINISH : qrr_pkg::S_SCAN;
        end
      end
      qrr_pkg::S_SCAN: begin
        if (status.hit) begin
          state_next = qrr_pkg::S_DELIVER;
        end else if (status.visit_done || scan_last) begin
          state_next = qrr_pkg::S_FINISH;
        end
      end
      qrr_pkg::S_DELIVER: begin
        if (!status.out_busy) begin
          state_next = qrr_pkg::S_IDLE;
        end
      end
      qrr_pkg::S_FINISH: begin
        if (!status.out_busy) begin
          state_next = qrr_pkg::S_IDLE;
        end
      end
      default: state_next = qrr_pkg::S_IDLE;
    endcase
  end

  // Command outputs to the datapath.
  always_comb begin
    cmd = '0;
    case (state)
      qrr_pkg::S_IDLE: begin
        if (accept) begin
          case (in_op)
            qrr_pkg::OP_CLEAR: cmd.clear      = 1'b1;
            qrr_pkg::OP_LOAD:  cmd.load       = 1'b1;
            qrr_pkg::OP_PULL:  cmd.pull_start = 1'b1;
            default:           cmd            = '0;
          endcase
        end
      end
      qrr_pkg::S_SCAN:    cmd.scan       = 1'b1;
      qrr_pkg::S_DELIVER: cmd.out_entry  = !status.out_busy;
      qrr_pkg::S_FINISH:  cmd.out_finish = !status.out_busy;
      default:            cmd            = '0;
    endcase
  end

  // State register and scan counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= qrr_pkg::S_IDLE;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      if (state != qrr_pkg::S_SCAN) begin
        scan_cnt <= '0;
      end else if (!status.hit) begin
        scan_cnt <= scan_cnt + SCAN_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qrr_dp.sv =====
// ----------------------------------------------------------------------------
// qrr_dp: merge datapath
// Configuration registers, entry memory, per-list counters, visit state and
// the output register. Evaluates one list visit per scan command.
// ----------------------------------------------------------------------------
`default_nettype none

module qrr_dp #(
  parameter int NUM_LISTS  = qrr_pkg::NUM_LISTS_DEF,
  parameter int LIST_DEPTH = qrr_pkg::LIST_DEPTH_DEF,
  parameter int TAG_WIDTH  = qrr_pkg::TAG_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire qrr_pkg::dp_cmd_t               cmd,
  output qrr_pkg::dp_status_t                 status,
  input  wire logic [qrr_pkg::LIST_IDX_W-1:0] list_index,
  input  wire logic [TAG_WIDTH-1:0]           item_tag,
  qrr_cfg_if.sink                             cfg,
  qrr_rsp_if.source                           rsp
);

  localparam int LI_W       = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int MEM_DEPTH  = NUM_LISTS * LIST_DEPTH;
  localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int EMIT_RAW_W = $clog2(MEM_DEPTH + 1);
  localparam int EMIT_W     = (EMIT_RAW_W > qrr_pkg::LIMIT_W) ? EMIT_RAW_W : qrr_pkg::LIMIT_W;
  localparam int CW         = qrr_pkg::CAP_W;
  localparam int AW         = qrr_pkg::ACT_W;
  localparam int IW         = qrr_pkg::LIST_IDX_W;
  localparam int QW         = qrr_pkg::QUOTA_W;

  // Configuration registers.
  logic [qrr_pkg::QUOTAS_W-1:0] quotas;
  logic [qrr_pkg::CAPS_W-1:0]   caps;
  logic [qrr_pkg::LIMIT_W-1:0]  total_limit;
  logic [qrr_pkg::LIU_W-1:0]    lists_in_use;

  // Batch state.
  logic [CNT_W-1:0]   list_lengths [NUM_LISTS];
  logic [CNT_W-1:0]   taken_counts [NUM_LISTS];
  logic [NUM_LISTS-1:0] settled;
  logic [EMIT_W-1:0]  emitted_total;
  logic [LI_W-1:0]    visit_list;
  logic [QW-1:0]      taken_this_visit;
  logic               overflow_mode;
  logic               merge_done;
  logic               pull_seen;

  // Entry memory.
  logic [TAG_WIDTH-1:0] entry_store [MEM_DEPTH];
  logic [TAG_WIDTH-1:0] rd_data;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ADDR_W-1:0]    mem_raddr;

  // Visit evaluation.
  logic [AW-1:0]      n_act;
  logic [AW-1:0]      visit_inc;
  logic [LI_W-1:0]    visit_wrap;
  logic [LI_W-1:0]    load_li;
  logic               load_ok;
  logic [CNT_W-1:0]   cur_len;
  logic [CNT_W-1:0]   cur_taken;
  logic [CW-1:0]      cur_cap;
  logic [QW-1:0]      cur_quota;
  logic               hit;
  logic               settle_now;
  logic               all_settled;
  logic [EMIT_W-1:0]  len_sum;
  logic               done_now;
  logic               limit_hit;

  // Output register.
  logic                 rsp_valid;
  logic [TAG_WIDTH-1:0] rsp_tag;
  logic [IW-1:0]        rsp_src;
  logic                 rsp_status;

  // Configuration writes; the port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quotas       <= qrr_pkg::QUOTAS_RST;
      caps         <= qrr_pkg::CAPS_RST;
      total_limit  <= qrr_pkg::LIMIT_RST;
      lists_in_use <= qrr_pkg::LISTS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        qrr_pkg::CFG_QUOTAS: quotas       <= cfg.data[qrr_pkg::QUOTAS_W-1:0];
        qrr_pkg::CFG_CAPS:   caps         <= cfg.data[qrr_pkg::CAPS_W-1:0];
        qrr_pkg::CFG_LIMIT:  total_limit  <= cfg.data[qrr_pkg::LIMIT_W-1:0];
        qrr_pkg::CFG_LISTS:  lists_in_use <= cfg.data[qrr_pkg::LIU_W-1:0];
        default:             quotas       <= quotas;
      endcase
    end
  end

  // Number of lists taking part, clamped to one through NUM_LISTS.
  always_comb begin
    if (lists_in_use == '0) begin
      n_act = AW'(1);
    end else if (AW'(lists_in_use) > AW'(NUM_LISTS)) begin
      n_act = AW'(NUM_LISTS);
    end else begin
      n_act = AW'(lists_in_use);
    end
  end

  // Load qualification and write address.
  assign load_li   = LI_W'(list_index);
  assign load_ok   = !pull_seen && (AW'(list_index) < AW'(NUM_LISTS)) &&
                     (list_lengths[load_li] < CNT_W'(LIST_DEPTH));
  assign mem_we    = cmd.load && load_ok;
  assign mem_waddr = ADDR_W'(ADDR_W'(load_li) * ADDR_W'(LIST_DEPTH) +
                             ADDR_W'(list_lengths[load_li]));

  // Current visit: can the visited list give an entry now?
  assign cur_len   = list_lengths[visit_list];
  assign cur_taken = taken_counts[visit_list];
  assign cur_cap   = qrr_pkg::cap_of(caps, IW'(visit_list));
  assign cur_quota = qrr_pkg::quota_of(quotas, IW'(visit_list));
  assign hit       = (taken_this_visit < cur_quota) && !settled[visit_list] &&
                     (cur_taken < cur_len) &&
                     ((CW'(cur_taken) < cur_cap) || overflow_mode);
  assign mem_raddr = ADDR_W'(ADDR_W'(visit_list) * ADDR_W'(LIST_DEPTH) +
                             ADDR_W'(cur_taken));
  assign limit_hit = ((emitted_total + EMIT_W'(1)) == EMIT_W'(total_limit));

  // End of a visit: settle check, overflow check over all lists in use.
  assign settle_now = (cur_cap >= CW'(cur_len)) && (cur_taken == cur_len);

  always_comb begin
    all_settled = 1'b1;
    len_sum     = '0;
    for (int j = 0; j < NUM_LISTS; j++) begin
      if (AW'(j) < n_act) begin
        if (!(settled[j] || (settle_now && (LI_W'(j) == visit_list))) &&
            (CW'(taken_counts[j]) != qrr_pkg::cap_of(caps, IW'(j)))) begin
          all_settled = 1'b0;
        end
        len_sum = len_sum + EMIT_W'(list_lengths[j]);
      end
    end
  end

  assign done_now  = (emitted_total >= len_sum);
  assign visit_inc = AW'(visit_list) + AW'(1);
  assign visit_wrap = (visit_inc >= n_act) ? '0 : LI_W'(visit_inc);

  // Entry memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_store[mem_waddr] <= item_tag;
    end
    if (cmd.scan && hit) begin
      rd_data <= entry_store[mem_raddr];
    end
  end

  // Batch state updates.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int j = 0; j < NUM_LISTS; j++) begin
        list_lengths[j] <= '0;
        taken_counts[j] <= '0;
      end
      settled          <= '0;
      emitted_total    <= '0;
      visit_list       <= '0;
      taken_this_visit <= '0;
      overflow_mode    <= 1'b0;
      merge_done       <= 1'b0;
      pull_seen        <= 1'b0;
    end else begin
      if (mem_we) begin
        list_lengths[load_li] <= list_lengths[load_li] + CNT_W'(1);
      end
      if (cmd.pull_start) begin
        pull_seen <= 1'b1;
        if (!merge_done && (AW'(visit_list) >= n_act)) begin
          visit_list       <= '0;
          taken_this_visit <= '0;
        end
      end
      if (cmd.scan) begin
        if (hit) begin
          taken_counts[visit_list] <= cur_taken + CNT_W'(1);
          taken_this_visit         <= taken_this_visit + QW'(1);
          emitted_total            <= emitted_total + EMIT_W'(1);
          if (limit_hit) begin
            merge_done <= 1'b1;
          end
        end else begin
          if (settle_now) begin
            settled[visit_list] <= 1'b1;
          end
          if (all_settled && (emitted_total < EMIT_W'(total_limit))) begin
            overflow_mode <= 1'b1;
          end
          if (done_now) begin
            merge_done <= 1'b1;
          end
          visit_list       <= visit_wrap;
          taken_this_visit <= '0;
        end
      end
      if (cmd.out_finish) begin
        merge_done <= 1'b1;
      end
    end
  end

  // Output register: holds one result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_entry || cmd.out_finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_entry) begin
      rsp_tag    <= rd_data;
      rsp_src    <= IW'(visit_list);
      rsp_status <= qrr_pkg::STATUS_ENTRY;
    end else if (cmd.out_finish) begin
      rsp_tag    <= '0;
      rsp_src    <= '0;
      rsp_status <= qrr_pkg::STATUS_DONE;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.merged_tag  = rsp_tag;
  assign rsp.source_list = rsp_src;
  assign rsp.pull_status = rsp_status;

  // Status to the controller.
  assign status.merge_done = merge_done;
  assign status.hit        = hit;
  assign status.visit_done = done_now;
  assign status.out_busy   = rsp_valid && !rsp.ready;

`ifndef SYNTHESIS
  // Each emitted entry advances the running total by exactly one.
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && hit && !cmd.clear) |=> (emitted_total == $past(emitted_total) + EMIT_W'(1)))
    else $error("emitted total did not advance on an emitted entry");

  // The finished flag drops only through a batch clear or reset.
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    $fell(merge_done) |-> ($past(cmd.clear) || $past(rst)))
    else $error("merge finished flag dropped without a clear");

  // Overflow mode, once entered, lasts until a clear or reset.
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    $fell(overflow_mode) |-> ($past(cmd.clear) || $past(rst)))
    else $error("overflow mode dropped without a clear");

  // A finished result carries no entry.
  a_done_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == qrr_pkg::STATUS_DONE)) |-> ((rsp_tag == '0) && (rsp_src == '0)))
    else $error("finished result carries a nonzero payload");

  // An entry is never read from a list that it has run past.
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && hit) |-> (cur_taken < cur_len))
    else $error("entry read beyond the loaded length");
`endif

endmodule

`default_nettype wire

// ===== rtl/quota_round_robin_list_merge.sv =====
// ----------------------------------------------------------------------------
// quota_round_robin_list_merge: weighted round-robin merge with per-list caps
// Category lists are loaded with entries and then drained, one entry per
// pull, by visiting the lists in turn with per-visit quotas and per-list caps.
//
//   Channel  Dir  Handshake      Payload
//   req      in   valid/ready    operation, list_index, item_tag
//   rsp      out  valid/ready    merged_tag, source_list, pull_status
//   cfg      in   valid/ready    index, data (always ready)
//
// Clear and load requests are taken in the idle state and leave it idle.
// A pull scans list visits until a hit, the end of the merge or the bound of
// 3 * NUM_LISTS + 3 visits; the visit loop evaluates one list per cycle.
// A pull on a finished merge gives the finished result without a scan.
// Synchronous reset restores the register defaults and an empty batch;
// the entry memory needs no clearing pass.
// A stalled response holds in the output register; requests that give no
// result are still taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module quota_round_robin_list_merge #(
  parameter int NUM_LISTS  = qrr_pkg::NUM_LISTS_DEF,
  parameter int LIST_DEPTH = qrr_pkg::LIST_DEPTH_DEF,
  parameter int TAG_WIDTH  = qrr_pkg::TAG_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  qrr_req_if.sink   req,
  qrr_rsp_if.source rsp,
  qrr_cfg_if.sink   cfg
);

  qrr_pkg::dp_cmd_t    cmd;
  qrr_pkg::dp_status_t status;

  // Sequencing of requests and the visit scan.
  qrr_ctrl #(
    .NUM_LISTS (NUM_LISTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.operation),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage, counters, visit evaluation and output register.
  qrr_dp #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .list_index (req.list_index),
    .item_tag   (req.item_tag),
    .cfg        (cfg),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the quota round-robin list merge
// A scoreboard class keeps its own model of the lists, the visit pointer, the
// caps and the overflow mode, predicts each pull's result when the request is
// accepted and checks every response transfer against the oldest prediction.
// Directed batches cover the special cases, then random batches run through
// several register settings and idle/stall phases.
// ----------------------------------------------------------------------------

module testbench;

  localparam int NUM_LISTS   = 6;
  localparam int LIST_DEPTH  = 64;
  localparam int TAG_W       = 16;
  localparam int SCAN_VISITS = 3 * NUM_LISTS + 3;
  localparam int DRAIN_CYCLES = SCAN_VISITS + 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 850;
  localparam int NUM_PHASES  = 8;
  localparam int REPORT_MAX  = 10;
  // Operation code that the block does not define.
  localparam logic [qrr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // One merged result as seen on the response channel.
  typedef struct packed {
    logic [TAG_W-1:0]               tag;
    logic [qrr_pkg::LIST_IDX_W-1:0] src;
    logic                           status;
  } merge_result_t;

  // Scoreboard: predicts the merge order and checks the responses.
  class merge_scoreboard;
    logic [qrr_pkg::QUOTAS_W-1:0] quotas;
    logic [qrr_pkg::CAPS_W-1:0]   caps;
    logic [qrr_pkg::LIMIT_W-1:0]  limit;
    logic [qrr_pkg::LIU_W-1:0]    lists;
    logic [TAG_W-1:0]    entries [NUM_LISTS*LIST_DEPTH];
    int unsigned         lengths [NUM_LISTS];
    int unsigned         taken [NUM_LISTS];
    bit                  settled [NUM_LISTS];
    int unsigned         emitted;
    int unsigned         visit;
    int unsigned         visit_taken;
    bit                  overflow;
    bit                  done;
    bit                  pulled;
    merge_result_t       expected_merges[$];
    int                  errors;
    int                  checked;

    function new();
      quotas = qrr_pkg::QUOTAS_RST;
      caps   = qrr_pkg::CAPS_RST;
      limit  = qrr_pkg::LIMIT_RST;
      lists  = qrr_pkg::LISTS_RST;
      errors = 0;
      checked = 0;
      clear_batch();
    endfunction

    function int outstanding();
      return expected_merges.size();
    endfunction

    function void write_reg(qrr_pkg::cfg_reg_t idx,
                            logic [qrr_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        qrr_pkg::CFG_QUOTAS: quotas = value[qrr_pkg::QUOTAS_W-1:0];
        qrr_pkg::CFG_CAPS:   caps   = value[qrr_pkg::CAPS_W-1:0];
        qrr_pkg::CFG_LIMIT:  limit  = value[qrr_pkg::LIMIT_W-1:0];
        qrr_pkg::CFG_LISTS:  lists  = value[qrr_pkg::LIU_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_count();
      if (lists < 1) return 1;
      if (lists > NUM_LISTS) return NUM_LISTS;
      return lists;
    endfunction

    // A zero quota field behaves as a quota of one.
    function int unsigned quota(int unsigned i);
      int unsigned q;
      q = quotas[4*i +: 4];
      return (q == 0) ? 1 : q;
    endfunction

    function int unsigned cap(int unsigned i);
      return caps[8*i +: 8];
    endfunction

    function void clear_batch();
      int i;
      for (i = 0; i < NUM_LISTS; i++) begin
        lengths[i] = 0;
        taken[i]   = 0;
        settled[i] = 0;
      end
      emitted = 0;
      visit = 0;
      visit_taken = 0;
      overflow = 0;
      done = 0;
      pulled = 0;
    endfunction

    // Close the current visit, update the settled bits and move on.
    function void close_visit(int unsigned n);
      int unsigned i;
      int unsigned j;
      int unsigned sum;
      bit          all_settled;
      i = visit;
      sum = 0;
      all_settled = 1;
      if (cap(i) >= lengths[i] && taken[i] == lengths[i]) settled[i] = 1;
      for (j = 0; j < n; j++) begin
        if (!settled[j] && taken[j] != cap(j)) all_settled = 0;
        sum += lengths[j];
      end
      if (all_settled && emitted < limit) overflow = 1;
      if (emitted >= sum) done = 1;
      visit = (i + 1 >= n) ? 0 : i + 1;
      visit_taken = 0;
    endfunction

    // Work out the result of one pull and advance the merge.
    function merge_result_t next_merged_entry();
      merge_result_t r;
      int unsigned   n;
      int unsigned   i;
      int            k;
      r.tag = '0;
      r.src = '0;
      r.status = qrr_pkg::STATUS_DONE;
      pulled = 1;
      if (done) return r;
      n = active_count();
      if (visit >= n) begin
        visit = 0;
        visit_taken = 0;
      end
      for (k = 0; k < SCAN_VISITS; k++) begin
        i = visit;
        if (visit_taken < quota(i) && !settled[i] && taken[i] < lengths[i] &&
            (taken[i] < cap(i) || overflow)) begin
          r.tag = entries[i*LIST_DEPTH + taken[i]];
          r.src = qrr_pkg::LIST_IDX_W'(i);
          r.status = qrr_pkg::STATUS_ENTRY;
          taken[i]++;
          visit_taken++;
          emitted++;
          if (emitted == limit) done = 1;
          return r;
        end
        close_visit(n);
        if (done) return r;
      end
      // The scan found nothing: the merge has stalled.
      done = 1;
      return r;
    endfunction

    function void note_request(logic [qrr_pkg::OP_W-1:0] op,
                               logic [qrr_pkg::LIST_IDX_W-1:0] li,
                               logic [TAG_W-1:0] tag);
      case (op)
        qrr_pkg::OP_CLEAR: clear_batch();
        qrr_pkg::OP_LOAD: begin
          if (!pulled && li < NUM_LISTS && lengths[li] < LIST_DEPTH) begin
            entries[li*LIST_DEPTH + lengths[li]] = tag;
            lengths[li]++;
          end
        end
        qrr_pkg::OP_PULL: expected_merges = {expected_merges, next_merged_entry()};
        default: ;
      endcase
    endfunction

    function void check_response(merge_result_t got);
      merge_result_t want;
      checked++;
      if (expected_merges.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("response %0d with nothing expected: tag %h list %0d status %0d",
                   checked, got.tag, got.src, got.status);
        return;
      end
      want = expected_merges.pop_front();
      if (got.tag !== want.tag || got.src !== want.src || got.status !== want.status) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display({"response %0d: expected tag %h list %0d status %0d, ",
                    "got tag %h list %0d status %0d"},
                   checked, want.tag, want.src, want.status, got.tag, got.src, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles = 0;
  int   items_sent = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  merge_scoreboard sb = new();

  qrr_req_if #(.TAG_W(TAG_W)) req_bus ();
  qrr_rsp_if #(.TAG_W(TAG_W)) rsp_bus ();
  qrr_cfg_if                  cfg_bus ();

  quota_round_robin_list_merge #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH),
    .TAG_WIDTH  (TAG_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitors: every transfer on each channel is handed to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready)
        sb.write_reg(qrr_pkg::cfg_reg_t'(cfg_bus.index), cfg_bus.data);
      if (req_bus.valid && req_bus.ready)
        sb.note_request(req_bus.operation, req_bus.list_index, req_bus.item_tag);
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_response({rsp_bus.merged_tag, rsp_bus.source_list, rsp_bus.pull_status});
    end
  end

  // Send one request, with random idle cycles before it.
  task automatic send_req(logic [qrr_pkg::OP_W-1:0] op,
                          logic [qrr_pkg::LIST_IDX_W-1:0] li,
                          logic [TAG_W-1:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.operation  <= op;
    req_bus.list_index <= li;
    req_bus.item_tag   <= tag;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    if (op != OP_UNUSED && !(op == qrr_pkg::OP_LOAD && li >= NUM_LISTS)) items_sent++;
  endtask

  // Let all pending responses arrive, then give the block time to settle.
  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(qrr_pkg::cfg_reg_t idx, logic [qrr_pkg::CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Register settings of one phase; the first phases take the extremes.
  task automatic configure_phase(int p);
    logic [qrr_pkg::CFG_DATA_W-1:0] q;
    logic [qrr_pkg::CFG_DATA_W-1:0] c;
    logic [qrr_pkg::CFG_DATA_W-1:0] l;
    logic [qrr_pkg::CFG_DATA_W-1:0] n;
    int                    i;
    int                    roll;
    q = qrr_pkg::CFG_DATA_W'({$urandom, $urandom});
    c = qrr_pkg::CFG_DATA_W'({$urandom, $urandom});
    l = qrr_pkg::CFG_DATA_W'({$urandom, $urandom});
    n = qrr_pkg::CFG_DATA_W'({$urandom, $urandom});
    case (p)
      0: begin
        q[qrr_pkg::QUOTAS_W-1:0] = '0;
        c[qrr_pkg::CAPS_W-1:0]   = '1;
        l[qrr_pkg::LIMIT_W-1:0]  = '1;
        n[qrr_pkg::LIU_W-1:0]    = 3'd7;
      end
      1: begin
        q[qrr_pkg::QUOTAS_W-1:0] = '1;
        c[qrr_pkg::CAPS_W-1:0]   = '0;
        l[qrr_pkg::LIMIT_W-1:0]  = 10'd1;
        n[qrr_pkg::LIU_W-1:0]    = 3'd0;
      end
      default: begin
        for (i = 0; i < NUM_LISTS; i++) begin
          q[4*i +: 4] = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
          c[8*i +: 8] = ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        end
        roll = $urandom_range(7);
        if (roll == 0) l[qrr_pkg::LIMIT_W-1:0] = '0;
        else if (roll < 4) l[qrr_pkg::LIMIT_W-1:0] = 10'($urandom_range(1, 12));
        else l[qrr_pkg::LIMIT_W-1:0] = 10'($urandom_range(13, 1023));
        n[qrr_pkg::LIU_W-1:0] = 3'($urandom_range(0, 7));
        if (p == 2) n[qrr_pkg::LIU_W-1:0] = 3'd1;
      end
    endcase
    write_reg(qrr_pkg::CFG_QUOTAS, q);
    write_reg(qrr_pkg::CFG_CAPS, c);
    write_reg(qrr_pkg::CFG_LIMIT, l);
    write_reg(qrr_pkg::CFG_LISTS, n);
  endtask

  // One random batch: an optional clear, loads with some noise, then pulls.
  task automatic run_batch(bit fresh);
    bit fill;
    int fill_list;
    int loads;
    int pulls;
    int k;
    int roll;
    if (fresh) send_req(qrr_pkg::OP_CLEAR, 3'($urandom), 16'($urandom));
    fill = ($urandom_range(39) == 0);
    fill_list = $urandom_range(NUM_LISTS - 1);
    loads = fill ? LIST_DEPTH + 2 : $urandom_range(0, 14);
    for (k = 0; k < loads; k++) begin
      roll = $urandom_range(19);
      if (roll == 0) send_req(OP_UNUSED, 3'($urandom), 16'($urandom));
      else if (roll == 1) send_req(qrr_pkg::OP_LOAD, 3'($urandom_range(6, 7)), 16'($urandom));
      send_req(qrr_pkg::OP_LOAD,
               fill ? 3'(fill_list) : 3'($urandom_range(NUM_LISTS - 1)),
               16'($urandom));
    end
    // Most batches drain fully; a few stop early so the merge carries on.
    if ($urandom_range(9) == 0) pulls = $urandom_range(0, loads / 2);
    else pulls = loads + $urandom_range(0, 3);
    for (k = 0; k < pulls; k++) begin
      if ($urandom_range(14) == 0) send_req(qrr_pkg::OP_LOAD, 3'($urandom), 16'($urandom));
      send_req(qrr_pkg::OP_PULL, 3'($urandom), 16'($urandom));
    end
  endtask

  // Directed batches for the extremes and the special cases.
  task automatic run_directed();
    // A pull on an empty batch finishes the merge at once.
    send_req(qrr_pkg::OP_PULL, 3'd0, 16'h0000);
    send_req(qrr_pkg::OP_CLEAR, 3'd7, 16'hFFFF);
    send_req(qrr_pkg::OP_LOAD, 3'd0, 16'h0000);
    send_req(qrr_pkg::OP_LOAD, 3'd0, 16'hFFFF);
    send_req(qrr_pkg::OP_LOAD, 3'd5, 16'hA5A5);
    // Loads to lists that do not exist and an undefined operation are dropped.
    send_req(qrr_pkg::OP_LOAD, 3'd6, 16'h1234);
    send_req(qrr_pkg::OP_LOAD, 3'd7, 16'h4321);
    send_req(OP_UNUSED, 3'd7, 16'hFFFF);
    send_req(qrr_pkg::OP_LOAD, 3'd2, 16'h5A5A);
    repeat (4) send_req(qrr_pkg::OP_PULL, 3'd5, 16'hFFFF);
    // A load once the batch has been pulled is ignored.
    send_req(qrr_pkg::OP_LOAD, 3'd1, 16'h00FF);
    repeat (2) send_req(qrr_pkg::OP_PULL, 3'd2, 16'h0F0F);
    drain();

    // Zero caps, zero quotas and no limit: the merge stalls.
    write_reg(qrr_pkg::CFG_QUOTAS, 48'h0);
    write_reg(qrr_pkg::CFG_CAPS, 48'h0);
    write_reg(qrr_pkg::CFG_LIMIT, 48'h0);
    write_reg(qrr_pkg::CFG_LISTS, 48'h7);
    send_req(qrr_pkg::OP_CLEAR, 3'd0, 16'h0000);
    send_req(qrr_pkg::OP_LOAD, 3'd3, 16'h0F0F);
    send_req(qrr_pkg::OP_LOAD, 3'd4, 16'hF0F0);
    repeat (2) send_req(qrr_pkg::OP_PULL, 3'd0, 16'h0000);
    drain();

    // A limit of one with a single list in use.
    write_reg(qrr_pkg::CFG_CAPS, 48'hFFFF_FFFF_FFFF);
    write_reg(qrr_pkg::CFG_LIMIT, 48'h1);
    write_reg(qrr_pkg::CFG_LISTS, 48'h0);
    send_req(qrr_pkg::OP_CLEAR, 3'd0, 16'h0000);
    send_req(qrr_pkg::OP_LOAD, 3'd0, 16'h8001);
    send_req(qrr_pkg::OP_LOAD, 3'd1, 16'h7FFE);
    repeat (2) send_req(qrr_pkg::OP_PULL, 3'd0, 16'h0000);
    drain();
  endtask

  // Main sequence.
  initial begin
    int p;
    int phase_end;
    bit first;
    rst <= 1'b1;
    req_bus.valid      <= 1'b0;
    req_bus.operation  <= qrr_pkg::OP_CLEAR;
    req_bus.list_index <= '0;
    req_bus.item_tag   <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= qrr_pkg::CFG_QUOTAS;
    cfg_bus.data       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    items_sent = 0;

    for (p = 0; p < NUM_PHASES; p++) begin
      // Idle modes: none, sender idle, receiver stalling, both.
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      configure_phase(p);
      phase_end = (p + 1) * ITEM_TARGET / NUM_PHASES;
      // The first batch of a phase may continue the previous merge.
      first = 1'b1;
      while (items_sent < phase_end) begin
        run_batch(first ? ($urandom_range(1) == 1) : ($urandom_range(9) != 0));
        first = 1'b0;
      end
      drain();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== quota_round_robin_list_merge.f =====
rtl/qrr_pkg.sv
rtl/qrr_ifs.sv
rtl/qrr_ctrl.sv
rtl/qrr_dp.sv
rtl/quota_round_robin_list_merge.sv
verif/testbench.sv
